FILE: design/mm64_pkg.sv
// shared types and constants for the murmur64a hash engine
`default_nettype none

package mm64_pkg;

	// input command codes carried in tuser
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_WORD   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// mixing constants
	localparam logic [63:0] MIX_MULT   = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT  = 47;
	localparam logic [63:0] SEED_RESET = 64'd2147483647;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LD_LEN,
		DP_LD_DATA,
		DP_LD_TAIL,
		DP_LD_HASH,
		DP_MUL,
		DP_XS,
		DP_W_XOR_H,
		DP_H_FROM_W,
		DP_H_SEED,
		DP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: design/murmur64a_hash_engine_top.sv
// top level of the murmur64a hash engine
`default_nettype none

// MurmurHash64A engine. A message is sent as a start transfer (tuser = 0, carries the total
// byte length), any number of word transfers (tuser = 1, eight little-endian bytes) and a
// finish transfer (tuser = 2, 0 to 7 tail bytes); the finish transfer returns one 64-bit
// hash on the master side. tuser = 3 is accepted and dropped. The seed register is written
// through cfg_wen/cfg_wdata; the user must write it only while the engine is idle, as the
// block itself does not enforce this. Items are handled one at a time, and a finish also
// waits for the previous hash to be taken. Every 64-bit multiply by the mixing constant is
// done in three passes of a single shared 32x32 multiplier. A finished hash sits in an
// output register, so the next message can start while the hash waits for its transfer.
module murmur64a_hash_engine_top
	import mm64_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// seed register write
	input  wire logic         cfg_wen,
	input  wire logic [63:0]  cfg_wdata,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: data_word[63:0], tail_bytes[66:64], message_length[98:67], zero pad[103:99]
	input  wire logic [103:0] s_tdata,
	// tuser: command[1:0]
	input  wire logic [1:0]   s_tuser,
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata: hash_value[63:0]
	output logic [63:0]       m_tdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: accepts a transfer only when idle
	mm64_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.command    (s_tuser),
		.tail_bytes (s_tdata[66:64]),
		.stat       (stat),
		.cmd        (cmd)
	);

	// fields are sampled by the datapath in the accept cycle only
	mm64_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.data_word      (s_tdata[63:0]),
		.tail_bytes     (s_tdata[66:64]),
		.message_length (s_tdata[98:67]),
		.cmd            (cmd),
		.stat           (stat),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule

`default_nettype wire

FILE: design/mm64_dp.sv
// datapath: seed, running hash, work register, shared 32x32 multiplier, output register
`default_nettype none

module mm64_dp
	import mm64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic [63:0] data_word,
	input  wire logic [2:0]  tail_bytes,
	input  wire logic [31:0] message_length,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata
);

	logic [63:0] seed_q;
	logic [63:0] hash_q;
	logic [63:0] w_q;
	logic [63:0] p_q;
	logic [63:0] out_q;
	logic        out_valid_q;

	logic [63:0] tail_mask;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] w_xs;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail_mask[i*8 +: 8] = (3'(i) < tail_bytes) ? 8'hff : 8'h00;
		end
	end

	// low 64 bits of w * M in three passes of one 32x32 multiplier
	assign mul_a = (cmd.step == 2'd2) ? w_q[63:32] : w_q[31:0];
	assign mul_b = (cmd.step == 2'd1) ? MIX_MULT[63:32] : MIX_MULT[31:0];
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	assign w_xs = w_q ^ (w_q >> MIX_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			hash_q      <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				seed_q <= cfg_wdata;
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				DP_H_FROM_W: hash_q <= w_q;
				DP_H_SEED:   hash_q <= seed_q ^ w_q;
				DP_OUT_LOAD: out_valid_q <= 1'b1;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LD_LEN:   w_q <= {32'd0, message_length};
			DP_LD_DATA:  w_q <= data_word;
			DP_LD_TAIL:  w_q <= hash_q ^ (data_word & tail_mask);
			DP_LD_HASH:  w_q <= hash_q;
			DP_XS:       w_q <= w_xs;
			DP_W_XOR_H:  w_q <= hash_q ^ w_q;
			DP_MUL: begin
				case (cmd.step)
					2'd0:    p_q <= mul_p;
					2'd1:    p_q[63:32] <= p_q[63:32] + mul_p[31:0];
					default: w_q <= {p_q[63:32] + mul_p[31:0], p_q[31:0]};
				endcase
			end
			DP_OUT_LOAD: out_q <= w_xs;
			default:     ;
		endcase
	end

	assign stat.out_full = out_valid_q;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_q;

endmodule

`default_nettype wire

FILE: design/mm64_ctrl.sv
// controller: sequences the datapath through each command
`default_nettype none

module mm64_ctrl
	import mm64_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [1:0] command,
	input  wire logic [2:0] tail_bytes,
	input  wire dp_stat_t   stat,
	output dp_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SEED = 3'd2;
	localparam logic [2:0] ST_WXS  = 3'd3;
	localparam logic [2:0] ST_WXH  = 3'd4;
	localparam logic [2:0] ST_WHW  = 3'd5;
	localparam logic [2:0] ST_FXS  = 3'd6;
	localparam logic [2:0] ST_FOUT = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [1:0] step_q, step_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		step_d   = 2'd0;
		cmd.op   = DP_NOP;
		cmd.step = step_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (command)
						CMD_START: begin
							cmd.op  = DP_LD_LEN;
							state_d = ST_MUL;
							ret_d   = ST_SEED;
						end
						CMD_WORD: begin
							cmd.op  = DP_LD_DATA;
							state_d = ST_MUL;
							ret_d   = ST_WXS;
						end
						CMD_FINISH: begin
							if (tail_bytes != 3'd0) begin
								cmd.op  = DP_LD_TAIL;
								state_d = ST_MUL;
								ret_d   = ST_FXS;
							end else begin
								cmd.op  = DP_LD_HASH;
								state_d = ST_FXS;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				cmd.op = DP_MUL;
				if (step_q == 2'd2) begin
					state_d = ret_q;
				end else begin
					step_d = step_q + 2'd1;
				end
			end
			ST_SEED: begin
				cmd.op  = DP_H_SEED;
				state_d = ST_IDLE;
			end
			ST_WXS: begin
				cmd.op  = DP_XS;
				state_d = ST_MUL;
				ret_d   = ST_WXH;
			end
			ST_WXH: begin
				cmd.op  = DP_W_XOR_H;
				state_d = ST_MUL;
				ret_d   = ST_WHW;
			end
			ST_WHW: begin
				cmd.op  = DP_H_FROM_W;
				state_d = ST_IDLE;
			end
			ST_FXS: begin
				cmd.op  = DP_XS;
				state_d = ST_MUL;
				ret_d   = ST_FOUT;
			end
			ST_FOUT: begin
				if (!stat.out_full) begin
					cmd.op  = DP_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			step_q  <= step_d;
		end
	end

`ifndef SYNTH
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q <= 2'd2))
		else $error("multiply step out of range");

	a_mul_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && step_q == 2'd2) |=> (state_q != ST_MUL))
		else $error("multiply did not return");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOUT && !stat.out_full) |=> stat.out_full)
		else $error("result not loaded into output register");
`endif

endmodule

`default_nettype wire
